// File: rtl/core/assert_macros.svh
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define AST_PROP(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("assertion failed");
`define AST_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");
`else
`define AST_PROP(lbl, clk, rst_n, prop)
`define AST_NEVER(lbl, clk, rst_n, cond)
`endif

`endif

// File: rtl/core/allp2_pkg.sv
// shared constants for the z^2 second-order allpass filter
`default_nettype none

package allp2_pkg;

	localparam int COEF_BITS       = 24;
	localparam int COEF_FRAC       = 22;
	localparam int CHAN_BITS       = 3;
	localparam int CFG_IDX_W       = 1;
	localparam int DEF_CHANNELS    = 8;
	localparam int DEF_SAMPLE_BITS = 24;

	localparam logic [CFG_IDX_W-1:0] REG_COEF_ONE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_TWO = 1'd1;

	typedef logic signed [COEF_BITS-1:0] coef_t;
	typedef logic [CHAN_BITS-1:0]        chan_t;

endpackage

`default_nettype wire

// File: rtl/core/allpass_z2_second_order.sv
// multichannel second-order allpass in z^2, registered in stage 1, stage 2 and output
// throughput one beat per cycle while m_tready allows, also back-to-back on one channel
// stage 1 reads the channel history and multiplies, stage 2 sums, rounds and saturates
// a channel's history shifts when its beat moves into the output register
// arst_n clears the coefficients, all histories and the valid flags at once
`default_nettype none
`include "assert_macros.svh"

module allpass_z2_second_order #(
	parameter int CHANNELS    = allp2_pkg::DEF_CHANNELS,
	parameter int SAMPLE_BITS = allp2_pkg::DEF_SAMPLE_BITS
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// config write port
	input  wire logic                                   cfg_we,
	input  wire logic [allp2_pkg::CFG_IDX_W-1:0]        cfg_index,
	input  wire logic [allp2_pkg::COEF_BITS-1:0]        cfg_data,
	// input stream
	input  wire logic                                   s_tvalid,
	output logic                                        s_tready,
	input  wire logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_tdata,  // sample_in
	input  wire logic [allp2_pkg::CHAN_BITS-1:0]        s_tuser,  // channel
	// output stream
	output logic                                        m_tvalid,
	input  wire logic                                   m_tready,
	output logic [((SAMPLE_BITS+7)/8)*8-1:0]            m_tdata,  // sample_out
	output logic [allp2_pkg::CHAN_BITS-1:0]             m_tuser   // channel_out
);
	import allp2_pkg::*;

	localparam int TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
	localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int DIFF_W   = SAMPLE_BITS + 1;
	localparam int PROD_W   = COEF_BITS + DIFF_W;
	localparam int ACC_W    = PROD_W + 2;
	localparam int YF_W     = ACC_W - COEF_FRAC;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (COEF_FRAC - 1));

	// coefficients
	coef_t coef_one_q, coef_two_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_one_q <= '0;
			coef_two_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COEF_ONE: coef_one_q <= cfg_data;
				REG_COEF_TWO: coef_two_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-channel histories, entry 0 is the newest
	logic signed [SAMPLE_BITS-1:0] xh_q [CHANNELS][4];
	logic signed [SAMPLE_BITS-1:0] yh_q [CHANNELS][4];

	// pipeline control
	logic s1_v, s2_v, out_v_q;
	logic out_free, s2_ready, s1_ready, s1_go, s2_go, in_go;

	assign out_free = !out_v_q || m_tready;
	assign s2_go    = s2_v && out_free;
	assign s2_ready = !s2_v || out_free;
	assign s1_go    = s1_v && s2_ready;
	assign s1_ready = !s1_v || s2_ready;
	assign s_tready = s1_ready;
	assign in_go    = s_tvalid && s1_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v    <= 1'b0;
			s2_v    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (in_go)
				s1_v <= 1'b1;
			else if (s1_go)
				s1_v <= 1'b0;
			if (s1_go)
				s2_v <= 1'b1;
			else if (s2_go)
				s2_v <= 1'b0;
			if (s2_go)
				out_v_q <= 1'b1;
			else if (m_tready)
				out_v_q <= 1'b0;
		end
	end

	// stage 1 registers
	logic signed [SAMPLE_BITS-1:0] x_s1;
	chan_t                         ch_s1;

	always_ff @(posedge clk) begin
		if (in_go) begin
			x_s1  <= s_tdata[SAMPLE_BITS-1:0];
			ch_s1 <= s_tuser;
		end
	end

	// stage 2 registers
	logic signed [PROD_W-1:0]      p1_s2, p2_s2;
	logic signed [SAMPLE_BITS-1:0] x_s2, x3_s2;
	chan_t                         ch_s2;
	logic                          inr_s2;

	// stage 1 logic: history read with a pending shift from stage 2
	logic                          inr_s1, fwd_s1;
	logic [CH_IDX_W-1:0]           idx_s1;
	logic signed [SAMPLE_BITS-1:0] x1_rd, y1_rd, x3_rd, y3_rd;
	logic signed [DIFF_W-1:0]      d1_s1, d2_s1;
	logic signed [PROD_W-1:0]      p1_s1, p2_s1;

	always_comb begin
		inr_s1 = (32'(ch_s1) < CHANNELS);
		idx_s1 = inr_s1 ? CH_IDX_W'(ch_s1) : '0;
		// an older beat of this channel in stage 2 shifts the row at this same edge
		fwd_s1 = s2_v && inr_s2 && (ch_s2 == ch_s1);
		x1_rd  = fwd_s1 ? xh_q[idx_s1][0] : xh_q[idx_s1][1];
		y1_rd  = fwd_s1 ? yh_q[idx_s1][0] : yh_q[idx_s1][1];
		x3_rd  = fwd_s1 ? xh_q[idx_s1][2] : xh_q[idx_s1][3];
		y3_rd  = fwd_s1 ? yh_q[idx_s1][2] : yh_q[idx_s1][3];
		d1_s1  = DIFF_W'(x1_rd) - DIFF_W'(y1_rd);
		d2_s1  = DIFF_W'(x_s1) - DIFF_W'(y3_rd);
		p1_s1  = PROD_W'(coef_one_q) * PROD_W'(d1_s1);
		p2_s1  = PROD_W'(coef_two_q) * PROD_W'(d2_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inr_s2 <= 1'b0;
		end else if (s1_go) begin
			inr_s2 <= inr_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			p1_s2 <= p1_s1;
			p2_s2 <= p2_s1;
			x_s2  <= x_s1;
			x3_s2 <= x3_rd;
			ch_s2 <= ch_s1;
		end
	end

	// stage 2 logic: sum, round half up, saturate
	logic signed [ACC_W-1:0]       acc_s2;
	logic signed [YF_W-1:0]        yf_s2;
	logic                          sat_hi, sat_lo;
	logic signed [SAMPLE_BITS-1:0] y_sat, y_s2;
	logic [CH_IDX_W-1:0]           idx_s2;

	always_comb begin
		acc_s2 = ACC_W'(p1_s2) + ACC_W'(p2_s2) + (ACC_W'(x3_s2) <<< COEF_FRAC) + ROUND_HALF;
		yf_s2  = YF_W'(acc_s2 >>> COEF_FRAC);
		sat_hi = !yf_s2[YF_W-1] && (|yf_s2[YF_W-2:SAMPLE_BITS-1]);
		sat_lo = yf_s2[YF_W-1] && !(&yf_s2[YF_W-2:SAMPLE_BITS-1]);
		if (sat_hi)
			y_sat = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
		else if (sat_lo)
			y_sat = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
		else
			y_sat = yf_s2[SAMPLE_BITS-1:0];
		y_s2   = inr_s2 ? y_sat : '0;
		idx_s2 = CH_IDX_W'(ch_s2);
	end

	// history shift as the beat leaves stage 2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < CHANNELS; c++) begin
				for (int k = 0; k < 4; k++) begin
					xh_q[c][k] <= '0;
					yh_q[c][k] <= '0;
				end
			end
		end else if (s2_go && inr_s2) begin
			xh_q[idx_s2][0] <= x_s2;
			yh_q[idx_s2][0] <= y_s2;
			for (int k = 1; k < 4; k++) begin
				xh_q[idx_s2][k] <= xh_q[idx_s2][k-1];
				yh_q[idx_s2][k] <= yh_q[idx_s2][k-1];
			end
		end
	end

	// output register
	logic [SAMPLE_BITS-1:0] y_out_q;
	chan_t                  ch_out_q;

	always_ff @(posedge clk) begin
		if (s2_go) begin
			y_out_q  <= y_s2;
			ch_out_q <= ch_s2;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = TDATA_W'(y_out_q);
	assign m_tuser  = ch_out_q;

	`AST_PROP(a_s2_to_out, clk, arst_n, s2_go |=> m_tvalid)
	`AST_PROP(a_in_to_s1, clk, arst_n, in_go |=> s1_v)
	`AST_NEVER(a_no_accept_when_full, clk, arst_n, s1_v && !s2_ready && s_tready)
	`AST_PROP(a_bad_chan_zero, clk, arst_n,
		(m_tvalid && !(32'(m_tuser) < CHANNELS)) |-> (y_out_q == '0))

endmodule

`default_nettype wire

// File: sim/tb_top.sv
// self-checking testbench for the z^2 second-order allpass filter
module tb_top;
	import allp2_pkg::*;

	localparam int CHANNELS      = DEF_CHANNELS;
	localparam int SMP_W         = DEF_SAMPLE_BITS;
	localparam longint SMP_MAX   = (64'sd1 <<< (SMP_W - 1)) - 1;
	localparam longint SMP_MIN   = -SMP_MAX - 1;
	localparam int DRAIN_PAUSE   = 8;
	localparam int NUM_PHASES    = 8;
	localparam int PHASE_ITEMS   = 250;
	localparam int CALM_PHASE    = 2;
	localparam int CALM_OUT_LO   = 600;
	localparam int CALM_OUT_HI   = 900;
	localparam int HOLD_AT       = 1300;
	localparam int HOLD_CYCLES   = 400;
	localparam int NUM_DIR       = 24;

	typedef struct packed {
		logic [SMP_W-1:0] smp;
		chan_t            ch;
	} sample_beat_t;

	typedef enum logic {ROW_COEFS, ROW_SAMPLE} row_kind_t;

	// a: sample or c1, b: c2, exp_smp valid only when has_exp is set
	typedef struct packed {
		row_kind_t        kind;
		logic [23:0]      a;
		logic [23:0]      b;
		chan_t            ch;
		logic             has_exp;
		logic [SMP_W-1:0] exp_smp;
	} dir_row_t;

	localparam dir_row_t DIR_ROWS [NUM_DIR] = '{
		// zero coefficients: output is the input four beats back on that channel
		'{ROW_SAMPLE, 24'h7FFFFF, 24'h0, 3'd0, 1'b1, 24'h000000},
		'{ROW_SAMPLE, 24'h800000, 24'h0, 3'd0, 1'b1, 24'h000000},
		'{ROW_SAMPLE, 24'h000001, 24'h0, 3'd0, 1'b1, 24'h000000},
		'{ROW_SAMPLE, 24'hFFFFFF, 24'h0, 3'd0, 1'b1, 24'h000000},
		'{ROW_SAMPLE, 24'h123456, 24'h0, 3'd0, 1'b1, 24'h7FFFFF},
		'{ROW_SAMPLE, 24'h000000, 24'h0, 3'd0, 1'b1, 24'h800000},
		'{ROW_SAMPLE, 24'h555555, 24'h0, 3'd7, 1'b1, 24'h000000},
		'{ROW_SAMPLE, 24'hAAAAAA, 24'h0, 3'd0, 1'b1, 24'h000001},
		// extreme coefficients, driving both saturation limits
		'{ROW_COEFS,  24'h7FFFFF, 24'h800000, 3'd0, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h7FFFFF, 24'h0, 3'd1, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h7FFFFF, 24'h0, 3'd1, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h800000, 24'h0, 3'd1, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h800000, 24'h0, 3'd1, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h7FFFFF, 24'h0, 3'd1, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h000000, 24'h0, 3'd1, 1'b0, 24'h0},
		'{ROW_COEFS,  24'h800000, 24'h7FFFFF, 3'd0, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h7FFFFF, 24'h0, 3'd2, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h800000, 24'h0, 3'd2, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h7FFFFF, 24'h0, 3'd2, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h800000, 24'h0, 3'd2, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h400000, 24'h0, 3'd2, 1'b0, 24'h0},
		// c2 = 0.5: exact halves round toward plus infinity
		'{ROW_COEFS,  24'h000000, 24'h200000, 3'd0, 1'b0, 24'h0},
		'{ROW_SAMPLE, 24'h000001, 24'h0, 3'd3, 1'b1, 24'h000001},
		'{ROW_SAMPLE, 24'hFFFFFF, 24'h0, 3'd3, 1'b1, 24'h000000}
	};

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_we;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [COEF_BITS-1:0]   cfg_data;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [SMP_W-1:0]       s_tdata;  // sample_in
	chan_t                  s_tuser;  // channel
	logic                   m_tvalid;
	logic                   m_tready;
	logic [SMP_W-1:0]       m_tdata;  // sample_out
	chan_t                  m_tuser;  // channel_out

	coef_t                  c1_q;
	coef_t                  c2_q;
	logic signed [SMP_W-1:0] x_hist [CHANNELS][4];
	logic signed [SMP_W-1:0] y_hist [CHANNELS][4];
	sample_beat_t           filt_expq [$];
	int                     n_in;
	int                     n_out;
	int                     n_settings;
	int                     bad_count;

	allpass_z2_second_order dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	always #6 clk = ~clk;

	// y = c1*(x[n-2] - y[n-2]) + c2*(x - y[n-4]) + x[n-4], rounded and clamped
	function automatic sample_beat_t allpass_predict(input logic [SMP_W-1:0] smp_bits,
			input chan_t ch);
		logic signed [SMP_W-1:0] x;
		longint acc;
		longint y;
		sample_beat_t r;
		x = smp_bits;
		y = 0;
		if (ch < CHANNELS) begin
			acc = longint'(c1_q) * (longint'(x_hist[ch][1]) - longint'(y_hist[ch][1]));
			acc += longint'(c2_q) * (longint'(x) - longint'(y_hist[ch][3]));
			acc += longint'(x_hist[ch][3]) <<< COEF_FRAC;
			acc += longint'(1) <<< (COEF_FRAC - 1);
			y = acc >>> COEF_FRAC;
			if (y > SMP_MAX)
				y = SMP_MAX;
			if (y < SMP_MIN)
				y = SMP_MIN;
			for (int k = 3; k > 0; k--) begin
				x_hist[ch][k] = x_hist[ch][k-1];
				y_hist[ch][k] = y_hist[ch][k-1];
			end
			x_hist[ch][0] = x;
			y_hist[ch][0] = y[SMP_W-1:0];
		end
		r.smp = y[SMP_W-1:0];
		r.ch = ch;
		return r;
	endfunction

	function automatic logic [SMP_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'($urandom_range(0, 511)) - 24'd256;
			3: return 24'h000000;
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic coef_t rand_coef();
		case ($urandom_range(0, 7))
			0: return 24'h7FFFFF;
			1: return 24'h800000;
			2: return 24'h000000;
			3: return 24'h400000;
			4: return 24'hC00000;
			default: return coef_t'($urandom);
		endcase
	endfunction

	task automatic flag_bad(input string what);
		bad_count++;
		if (bad_count <= 10)
			$display("ERROR at %0t: %s", $time, what);
	endtask

	// only while idle: wait out the pipeline, then write both coefficients
	task automatic set_coefs(input coef_t c1, input coef_t c2);
		s_tvalid <= 1'b0;
		do @(posedge clk); while (filt_expq.size() != 0);
		repeat (DRAIN_PAUSE) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= REG_COEF_ONE;
		cfg_data <= c1;
		@(posedge clk);
		cfg_index <= REG_COEF_TWO;
		cfg_data <= c2;
		@(posedge clk);
		cfg_we <= 1'b0;
		c1_q = c1;
		c2_q = c2;
		n_settings++;
	endtask

	task automatic send_sample(input logic [SMP_W-1:0] smp, input chan_t ch, input bit calm,
			input bit has_exp, input logic [SMP_W-1:0] exp_smp);
		sample_beat_t want;
		while (!calm && $urandom_range(0, 99) < 33) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= smp;
		s_tuser <= ch;
		do @(posedge clk); while (!s_tready);
		want = allpass_predict(smp, ch);
		if (has_exp)
			want.smp = exp_smp;
		filt_expq.push_back(want);
		n_in++;
	endtask

	// output side readiness, with one long hold-off to back the pipeline up
	initial begin
		bit held;
		held = 1'b0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (!held && n_out >= HOLD_AT) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			m_tready <= (n_out >= CALM_OUT_LO && n_out < CALM_OUT_HI) ||
				($urandom_range(0, 99) >= 33);
		end
	end

	always @(posedge clk) begin
		sample_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (filt_expq.size() == 0) begin
				flag_bad($sformatf("unexpected beat: sample %h channel %0d", m_tdata, m_tuser));
			end else begin
				want = filt_expq.pop_front();
				if (m_tdata !== want.smp || m_tuser !== want.ch)
					flag_bad($sformatf("beat %0d: expected sample %h channel %0d, got %h %0d",
						n_out, want.smp, want.ch, m_tdata, m_tuser));
			end
			n_out++;
		end
	end

	initial begin
		#(12 * 600000);
		$display("timeout with %0d results still outstanding", filt_expq.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		chan_t ch;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		c1_q = '0;
		c2_q = '0;
		n_in = 0;
		n_out = 0;
		n_settings = 0;
		bad_count = 0;
		ch = '0;
		foreach (x_hist[c, k]) begin
			x_hist[c][k] = '0;
			y_hist[c][k] = '0;
		end
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < NUM_DIR; i++) begin
			if (DIR_ROWS[i].kind == ROW_COEFS)
				set_coefs(DIR_ROWS[i].a, DIR_ROWS[i].b);
			else
				send_sample(DIR_ROWS[i].a, DIR_ROWS[i].ch, 1'b0,
					DIR_ROWS[i].has_exp, DIR_ROWS[i].exp_smp);
		end

		// random phases: new coefficients each time, bursts often stay on one channel
		for (int p = 0; p < NUM_PHASES; p++) begin
			set_coefs(rand_coef(), rand_coef());
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				if ($urandom_range(0, 1))
					ch = chan_t'($urandom_range(0, CHANNELS - 1));
				send_sample(rand_sample(), ch, p == CALM_PHASE, 1'b0, '0);
			end
		end
		s_tvalid <= 1'b0;

		do @(posedge clk); while (filt_expq.size() != 0);
		repeat (20) @(posedge clk);

		$display("sent %0d samples on %0d channels under %0d coefficient settings",
			n_in, CHANNELS, n_settings);
		$display("checked %0d filtered beats, %0d of them wrong or unexpected",
			n_out, bad_count);
		if (bad_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
